/* design/mid_pkg.sv */
// Shared definitions for the MIPS instruction decoder: field widths,
// opcode and function codes, and the instruction number encoding.
// No dependencies.
package mid_pkg;

   // Field widths of the instruction word and of the result word.
   localparam int unsigned WORD_W  = 32;
   localparam int unsigned ID_W    = 6;
   localparam int unsigned REG_W   = 5;
   localparam int unsigned IMM_W   = 16;
   localparam int unsigned TGT_W   = 26;
   localparam int unsigned OP_W    = 6;
   localparam int unsigned FN_W    = 6;
   localparam int unsigned CODE_W  = 20;

   // Primary opcodes.
   localparam logic [OP_W-1:0] OP_SPECIAL = 6'h00;
   localparam logic [OP_W-1:0] OP_REGIMM  = 6'h01;
   localparam logic [OP_W-1:0] OP_J       = 6'h02;
   localparam logic [OP_W-1:0] OP_JAL     = 6'h03;
   localparam logic [OP_W-1:0] OP_BEQ     = 6'h04;
   localparam logic [OP_W-1:0] OP_BNE     = 6'h05;
   localparam logic [OP_W-1:0] OP_BLEZ    = 6'h06;
   localparam logic [OP_W-1:0] OP_BGTZ    = 6'h07;
   localparam logic [OP_W-1:0] OP_ADDI    = 6'h08;
   localparam logic [OP_W-1:0] OP_ADDIU   = 6'h09;
   localparam logic [OP_W-1:0] OP_SLTI    = 6'h0A;
   localparam logic [OP_W-1:0] OP_SLTIU   = 6'h0B;
   localparam logic [OP_W-1:0] OP_ANDI    = 6'h0C;
   localparam logic [OP_W-1:0] OP_ORI     = 6'h0D;
   localparam logic [OP_W-1:0] OP_XORI    = 6'h0E;
   localparam logic [OP_W-1:0] OP_LUI     = 6'h0F;
   localparam logic [OP_W-1:0] OP_COP0    = 6'h10;
   localparam logic [OP_W-1:0] OP_LB      = 6'h20;
   localparam logic [OP_W-1:0] OP_LH      = 6'h21;
   localparam logic [OP_W-1:0] OP_LW      = 6'h23;
   localparam logic [OP_W-1:0] OP_LBU     = 6'h24;
   localparam logic [OP_W-1:0] OP_LHU     = 6'h25;
   localparam logic [OP_W-1:0] OP_SB      = 6'h28;
   localparam logic [OP_W-1:0] OP_SH      = 6'h29;
   localparam logic [OP_W-1:0] OP_SW      = 6'h2B;

   // Function codes under the special opcode.
   localparam logic [FN_W-1:0] FN_SLL     = 6'h00;
   localparam logic [FN_W-1:0] FN_SRL     = 6'h02;
   localparam logic [FN_W-1:0] FN_SRA     = 6'h03;
   localparam logic [FN_W-1:0] FN_SLLV    = 6'h04;
   localparam logic [FN_W-1:0] FN_SRLV    = 6'h06;
   localparam logic [FN_W-1:0] FN_SRAV    = 6'h07;
   localparam logic [FN_W-1:0] FN_JR      = 6'h08;
   localparam logic [FN_W-1:0] FN_JALR    = 6'h09;
   localparam logic [FN_W-1:0] FN_SYSCALL = 6'h0C;
   localparam logic [FN_W-1:0] FN_BREAK   = 6'h0D;
   localparam logic [FN_W-1:0] FN_MFHI    = 6'h10;
   localparam logic [FN_W-1:0] FN_MTHI    = 6'h11;
   localparam logic [FN_W-1:0] FN_MFLO    = 6'h12;
   localparam logic [FN_W-1:0] FN_MTLO    = 6'h13;
   localparam logic [FN_W-1:0] FN_MULT    = 6'h18;
   localparam logic [FN_W-1:0] FN_MULTU   = 6'h19;
   localparam logic [FN_W-1:0] FN_DIV     = 6'h1A;
   localparam logic [FN_W-1:0] FN_DIVU    = 6'h1B;
   localparam logic [FN_W-1:0] FN_ADD     = 6'h20;
   localparam logic [FN_W-1:0] FN_ADDU    = 6'h21;
   localparam logic [FN_W-1:0] FN_SUB     = 6'h22;
   localparam logic [FN_W-1:0] FN_SUBU    = 6'h23;
   localparam logic [FN_W-1:0] FN_AND     = 6'h24;
   localparam logic [FN_W-1:0] FN_OR      = 6'h25;
   localparam logic [FN_W-1:0] FN_XOR     = 6'h26;
   localparam logic [FN_W-1:0] FN_NOR     = 6'h27;
   localparam logic [FN_W-1:0] FN_SLT     = 6'h2A;
   localparam logic [FN_W-1:0] FN_SLTU    = 6'h2B;

   // Coprocessor-0 codes.
   localparam logic [FN_W-1:0]   FN_ERET   = 6'h18;
   localparam logic [REG_W-1:0]  RS_MF     = 5'h00;
   localparam logic [REG_W-1:0]  RS_MT     = 5'h04;
   localparam logic [CODE_W-1:0] ERET_CODE = 20'h80000;

   // Branch selectors in the rt field under the regimm opcode.
   localparam logic [REG_W-1:0] RT_BLTZ   = 5'h00;
   localparam logic [REG_W-1:0] RT_BGEZ   = 5'h01;
   localparam logic [REG_W-1:0] RT_BLTZAL = 5'h10;
   localparam logic [REG_W-1:0] RT_BGEZAL = 5'h11;

   // Instruction numbers reported on the result channel.
   typedef enum logic [ID_W-1:0] {
      ID_NOP = 6'd0,
      ID_ADD, ID_ADDU, ID_SUB, ID_SUBU, ID_AND, ID_OR, ID_XOR, ID_NOR,
      ID_SLT, ID_SLTU, ID_SLLV, ID_SRLV, ID_SRAV,
      ID_MULT, ID_MULTU, ID_DIV, ID_DIVU,
      ID_MFHI, ID_MFLO, ID_MTHI, ID_MTLO, ID_JR, ID_JALR,
      ID_SLL, ID_SRL, ID_SRA, ID_BREAK, ID_SYSCALL,
      ID_MFC0, ID_MTC0, ID_ERET,
      ID_ADDI, ID_ADDIU, ID_ANDI, ID_ORI, ID_XORI, ID_LUI,
      ID_LB, ID_LBU, ID_LH, ID_LHU, ID_LW, ID_SB, ID_SH, ID_SW,
      ID_BEQ, ID_BNE, ID_BGEZ, ID_BGTZ, ID_BLEZ, ID_BLTZ, ID_BGEZAL, ID_BLTZAL,
      ID_SLTI, ID_SLTIU, ID_J, ID_JAL,
      ID_UNKNOWN
   } insn_id_type;

endpackage

/* design/mips_instruction_decoder_core.sv */
// Top level of the MIPS instruction decoder: input register, classifier, result register.
// Depends on mid_pkg and mid_decode.
//
// Usage:
// The request side presents an instruction word on req_instr_word and raises
// start; the word is taken at a rising edge where start is high and busy is low.
// busy never rises, so a new word can be taken at every clock edge.
// Each word yields exactly one result word: rsp_strobe is high for one cycle
// while rsp_insn_id and the raw operand fields (rs, rt, rd, shamt, immediate
// and 26-bit target) are valid. The result is taken at the edge ending that cycle.
// A taken word passes two register stages, input word then result, before it
// appears on the result ports.
// Throughput: one word per cycle, set by the single classifier pass between
// the two registers.
// Reset (synchronous, active high) clears both valid flags; no result is shown
// afterwards until a new word is taken.
// The receiver cannot stall: results are presented once and are not held.
module mips_instruction_decoder_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [mid_pkg::WORD_W-1:0]    req_instr_word,
   output logic                          rsp_strobe,
   output logic [mid_pkg::ID_W-1:0]      rsp_insn_id,
   output logic [mid_pkg::REG_W-1:0]     rsp_src_reg,
   output logic [mid_pkg::REG_W-1:0]     rsp_tgt_reg,
   output logic [mid_pkg::REG_W-1:0]     rsp_dst_reg,
   output logic [mid_pkg::REG_W-1:0]     rsp_shift_amount,
   output logic [mid_pkg::IMM_W-1:0]     rsp_immediate,
   output logic [mid_pkg::TGT_W-1:0]     rsp_target
);
   import mid_pkg::*;

   logic              accept;
   logic              word_valid_ff;
   logic              word_valid_in;
   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;
   insn_id_type       dec_id;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [ID_W-1:0]   rsp_id_in;
   logic [WORD_W-1:0] rsp_word_ff;
   logic [WORD_W-1:0] rsp_word_in;

   // The pipeline never backs up, so the block is always ready.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Input stage: capture the word on accept.
   assign word_valid_in = accept;
   assign word_in       = accept ? req_instr_word : word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= 1'b0;
      end else begin
         word_valid_ff <= word_valid_in;
      end
      word_ff <= word_in;
   end

   mid_decode u_decode (
      .word    (word_ff),
      .insn_id (dec_id)
   );

   // Result stage: instruction number plus the word the raw fields come from.
   assign rsp_valid_in = word_valid_ff;
   assign rsp_id_in    = word_valid_ff ? ID_W'(dec_id) : rsp_id_ff;
   assign rsp_word_in  = word_valid_ff ? word_ff : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_id_ff   <= rsp_id_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_strobe       = rsp_valid_ff;
   assign rsp_insn_id      = rsp_id_ff;
   assign rsp_src_reg      = rsp_word_ff[25:21];
   assign rsp_tgt_reg      = rsp_word_ff[20:16];
   assign rsp_dst_reg      = rsp_word_ff[15:11];
   assign rsp_shift_amount = rsp_word_ff[10:6];
   assign rsp_immediate    = rsp_word_ff[15:0];
   assign rsp_target       = rsp_word_ff[25:0];

endmodule

/* design/mid_decode.sv */
// Combinational classifier: maps one instruction word to its instruction number.
// Depends on mid_pkg for the opcode, function and instruction codes.
module mid_decode (
   input  logic [mid_pkg::WORD_W-1:0] word,
   output mid_pkg::insn_id_type       insn_id
);
   import mid_pkg::*;

   logic [OP_W-1:0]  op;
   logic [REG_W-1:0] rs;
   logic [REG_W-1:0] rt;
   logic [REG_W-1:0] rd;
   logic [REG_W-1:0] sh;
   logic [FN_W-1:0]  fn;
   insn_id_type      spec_id;
   insn_id_type      cop0_id;
   insn_id_type      main_id;

   assign op = word[31:26];
   assign rs = word[25:21];
   assign rt = word[20:16];
   assign rd = word[15:11];
   assign sh = word[10:6];
   assign fn = word[5:0];

   // Special opcode: each function code owns one arm, with its zero-field checks.
   always_comb begin
      spec_id = ID_UNKNOWN;
      unique case (fn)
         FN_ADD:     if (sh == '0) spec_id = ID_ADD;
         FN_ADDU:    if (sh == '0) spec_id = ID_ADDU;
         FN_SUB:     if (sh == '0) spec_id = ID_SUB;
         FN_SUBU:    if (sh == '0) spec_id = ID_SUBU;
         FN_AND:     if (sh == '0) spec_id = ID_AND;
         FN_OR:      if (sh == '0) spec_id = ID_OR;
         FN_XOR:     if (sh == '0) spec_id = ID_XOR;
         FN_NOR:     if (sh == '0) spec_id = ID_NOR;
         FN_SLT:     if (sh == '0) spec_id = ID_SLT;
         FN_SLTU:    if (sh == '0) spec_id = ID_SLTU;
         FN_SLLV:    if (sh == '0) spec_id = ID_SLLV;
         FN_SRLV:    if (sh == '0) spec_id = ID_SRLV;
         FN_SRAV:    if (sh == '0) spec_id = ID_SRAV;
         FN_MULT:    if (sh == '0 && rd == '0) spec_id = ID_MULT;
         FN_MULTU:   if (sh == '0 && rd == '0) spec_id = ID_MULTU;
         FN_DIV:     if (sh == '0 && rd == '0) spec_id = ID_DIV;
         FN_DIVU:    if (sh == '0 && rd == '0) spec_id = ID_DIVU;
         FN_MFHI:    if (sh == '0 && rs == '0 && rt == '0) spec_id = ID_MFHI;
         FN_MFLO:    if (sh == '0 && rs == '0 && rt == '0) spec_id = ID_MFLO;
         FN_MTHI:    if (sh == '0 && rt == '0 && rd == '0) spec_id = ID_MTHI;
         FN_MTLO:    if (sh == '0 && rt == '0 && rd == '0) spec_id = ID_MTLO;
         FN_JR:      if (sh == '0 && rt == '0 && rd == '0) spec_id = ID_JR;
         FN_JALR:    if (sh == '0 && rt == '0) spec_id = ID_JALR;
         FN_SLL:     if (rs == '0) spec_id = ID_SLL;
         FN_SRL:     if (rs == '0) spec_id = ID_SRL;
         FN_SRA:     if (rs == '0) spec_id = ID_SRA;
         FN_BREAK:   spec_id = ID_BREAK;
         FN_SYSCALL: spec_id = ID_SYSCALL;
         default:    spec_id = ID_UNKNOWN;
      endcase
   end

   // Coprocessor 0: register moves need a clear shift field; eret has a fixed code.
   always_comb begin
      cop0_id = ID_UNKNOWN;
      if (sh == '0 && fn == FN_SLL) begin
         if (rs == RS_MF) cop0_id = ID_MFC0;
         else if (rs == RS_MT) cop0_id = ID_MTC0;
      end else if (word[25:6] == ERET_CODE && fn == FN_ERET) begin
         cop0_id = ID_ERET;
      end
   end

   // Primary opcode selects the group; immediate and jump forms resolve here.
   always_comb begin
      main_id = ID_UNKNOWN;
      unique case (op)
         OP_SPECIAL: main_id = spec_id;
         OP_COP0:    main_id = cop0_id;
         OP_ADDI:    main_id = ID_ADDI;
         OP_ADDIU:   main_id = ID_ADDIU;
         OP_ANDI:    main_id = ID_ANDI;
         OP_ORI:     main_id = ID_ORI;
         OP_XORI:    main_id = ID_XORI;
         OP_LUI:     if (rs == '0) main_id = ID_LUI;
         OP_LB:      main_id = ID_LB;
         OP_LBU:     main_id = ID_LBU;
         OP_LH:      main_id = ID_LH;
         OP_LHU:     main_id = ID_LHU;
         OP_LW:      main_id = ID_LW;
         OP_SB:      main_id = ID_SB;
         OP_SH:      main_id = ID_SH;
         OP_SW:      main_id = ID_SW;
         OP_BEQ:     main_id = ID_BEQ;
         OP_BNE:     main_id = ID_BNE;
         OP_BGTZ:    if (rt == '0) main_id = ID_BGTZ;
         OP_BLEZ:    if (rt == '0) main_id = ID_BLEZ;
         OP_REGIMM: begin
            unique case (rt)
               RT_BGEZ:   main_id = ID_BGEZ;
               RT_BLTZ:   main_id = ID_BLTZ;
               RT_BGEZAL: main_id = ID_BGEZAL;
               RT_BLTZAL: main_id = ID_BLTZAL;
               default:   main_id = ID_UNKNOWN;
            endcase
         end
         OP_SLTI:    main_id = ID_SLTI;
         OP_SLTIU:   main_id = ID_SLTIU;
         OP_J:       main_id = ID_J;
         OP_JAL:     main_id = ID_JAL;
         default:    main_id = ID_UNKNOWN;
      endcase
   end

   // The all-zero word is a nop and never reported as a shift.
   assign insn_id = (word == '0) ? ID_NOP : main_id;

endmodule

/* bench/tb_top.sv */
// Self-checking bench for the MIPS instruction decoder: drives instruction words with
// random start gaps and checks every decoded result against an internal classifier.
// Depends on mid_pkg and mips_instruction_decoder_core.
module tb_top;
   import mid_pkg::*;

   localparam int unsigned RANDOM_WORDS = 1850;
   localparam int unsigned LIMIT_CYCLES = 200000;
   localparam int unsigned DRAIN_CYCLES = 8;
   localparam int unsigned CALM_TAIL    = 200;

   // One decoded result as the block should report it.
   typedef struct {
      logic [WORD_W-1:0] word;
      insn_id_type       id;
      logic [REG_W-1:0]  rs;
      logic [REG_W-1:0]  rt;
      logic [REG_W-1:0]  rd;
      logic [REG_W-1:0]  sh;
      logic [IMM_W-1:0]  imm;
      logic [TGT_W-1:0]  tgt;
   } decoded_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic [WORD_W-1:0]   req_instr_word = '0;
   logic                busy;
   logic                rsp_strobe;
   logic [ID_W-1:0]     rsp_insn_id;
   logic [REG_W-1:0]    rsp_src_reg;
   logic [REG_W-1:0]    rsp_tgt_reg;
   logic [REG_W-1:0]    rsp_dst_reg;
   logic [REG_W-1:0]    rsp_shift_amount;
   logic [IMM_W-1:0]    rsp_immediate;
   logic [TGT_W-1:0]    rsp_target;

   logic [WORD_W-1:0]   word_q[$];
   decoded_type         decoded_q[$];
   int unsigned         sent_count = 0;
   int unsigned         taken_count = 0;
   int unsigned         gap_left = 0;
   int unsigned         cycle_count = 0;
   int unsigned         fail_count = 0;

   mips_instruction_decoder_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_instr_word   (req_instr_word),
      .rsp_strobe       (rsp_strobe),
      .rsp_insn_id      (rsp_insn_id),
      .rsp_src_reg      (rsp_src_reg),
      .rsp_tgt_reg      (rsp_tgt_reg),
      .rsp_dst_reg      (rsp_dst_reg),
      .rsp_shift_amount (rsp_shift_amount),
      .rsp_immediate    (rsp_immediate),
      .rsp_target       (rsp_target)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock) reset <= 1'b0;
   end

   // Classify a word by the decoder's priority: special forms, then
   // coprocessor-0 forms, then immediate forms, then jumps.
   function automatic insn_id_type classify_word(input logic [WORD_W-1:0] w);
      logic [OP_W-1:0]  op;
      logic [REG_W-1:0] rs;
      logic [REG_W-1:0] rt;
      logic [REG_W-1:0] rd;
      logic [REG_W-1:0] sh;
      logic [FN_W-1:0]  fn;
      op = w[31:26];
      rs = w[25:21];
      rt = w[20:16];
      rd = w[15:11];
      sh = w[10:6];
      fn = w[5:0];
      if (w == '0)
         return ID_NOP;
      if (op == OP_SPECIAL) begin
         if (sh == '0) begin
            case (fn)
               FN_ADD:   return ID_ADD;
               FN_ADDU:  return ID_ADDU;
               FN_SUB:   return ID_SUB;
               FN_SUBU:  return ID_SUBU;
               FN_AND:   return ID_AND;
               FN_OR:    return ID_OR;
               FN_XOR:   return ID_XOR;
               FN_NOR:   return ID_NOR;
               FN_SLT:   return ID_SLT;
               FN_SLTU:  return ID_SLTU;
               FN_SLLV:  return ID_SLLV;
               FN_SRLV:  return ID_SRLV;
               FN_SRAV:  return ID_SRAV;
               FN_MULT:  if (rd == '0) return ID_MULT;
               FN_MULTU: if (rd == '0) return ID_MULTU;
               FN_DIV:   if (rd == '0) return ID_DIV;
               FN_DIVU:  if (rd == '0) return ID_DIVU;
               FN_MFHI:  if (rs == '0 && rt == '0) return ID_MFHI;
               FN_MFLO:  if (rs == '0 && rt == '0) return ID_MFLO;
               FN_MTHI:  if (rt == '0 && rd == '0) return ID_MTHI;
               FN_MTLO:  if (rt == '0 && rd == '0) return ID_MTLO;
               FN_JR:    if (rt == '0 && rd == '0) return ID_JR;
               FN_JALR:  if (rt == '0) return ID_JALR;
               default: ;
            endcase
         end
         // Shifts by constant may carry any shift amount but need rs clear.
         if (rs == '0) begin
            if (fn == FN_SLL) return ID_SLL;
            if (fn == FN_SRL) return ID_SRL;
            if (fn == FN_SRA) return ID_SRA;
         end
         if (fn == FN_BREAK) return ID_BREAK;
         if (fn == FN_SYSCALL) return ID_SYSCALL;
      end
      if (op == OP_COP0) begin
         if (sh == '0 && fn == '0) begin
            if (rs == RS_MF) return ID_MFC0;
            if (rs == RS_MT) return ID_MTC0;
         end
         if (w[25:6] == ERET_CODE && fn == FN_ERET) return ID_ERET;
      end
      case (op)
         OP_ADDI:   return ID_ADDI;
         OP_ADDIU:  return ID_ADDIU;
         OP_ANDI:   return ID_ANDI;
         OP_ORI:    return ID_ORI;
         OP_XORI:   return ID_XORI;
         OP_LUI:    if (rs == '0) return ID_LUI;
         OP_LB:     return ID_LB;
         OP_LBU:    return ID_LBU;
         OP_LH:     return ID_LH;
         OP_LHU:    return ID_LHU;
         OP_LW:     return ID_LW;
         OP_SB:     return ID_SB;
         OP_SH:     return ID_SH;
         OP_SW:     return ID_SW;
         OP_BEQ:    return ID_BEQ;
         OP_BNE:    return ID_BNE;
         OP_BGTZ:   if (rt == '0) return ID_BGTZ;
         OP_BLEZ:   if (rt == '0) return ID_BLEZ;
         OP_REGIMM: begin
            if (rt == RT_BGEZ) return ID_BGEZ;
            if (rt == RT_BLTZ) return ID_BLTZ;
            if (rt == RT_BGEZAL) return ID_BGEZAL;
            if (rt == RT_BLTZAL) return ID_BLTZAL;
         end
         OP_SLTI:   return ID_SLTI;
         OP_SLTIU:  return ID_SLTIU;
         OP_J:      return ID_J;
         OP_JAL:    return ID_JAL;
         default: ;
      endcase
      return ID_UNKNOWN;
   endfunction

   // The operand fields are always the raw slices of the word.
   function automatic decoded_type decode_expected(input logic [WORD_W-1:0] w);
      decoded_type d;
      d.word = w;
      d.id   = classify_word(w);
      d.rs   = w[25:21];
      d.rt   = w[20:16];
      d.rd   = w[15:11];
      d.sh   = w[10:6];
      d.imm  = w[15:0];
      d.tgt  = w[25:0];
      return d;
   endfunction

   // Build a well-formed word for the given instruction with random operands;
   // operands are sometimes all zero or all one to reach the field extremes.
   function automatic logic [WORD_W-1:0] build_word(input insn_id_type id);
      logic [WORD_W-1:0] w;
      case ($urandom_range(0, 7))
         0: w = '0;
         1: w = '1;
         default: w = $urandom;
      endcase
      case (id)
         ID_NOP:     w = '0;
         ID_ADD:     {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_ADD};
         ID_ADDU:    {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_ADDU};
         ID_SUB:     {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_SUB};
         ID_SUBU:    {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_SUBU};
         ID_AND:     {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_AND};
         ID_OR:      {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_OR};
         ID_XOR:     {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_XOR};
         ID_NOR:     {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_NOR};
         ID_SLT:     {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_SLT};
         ID_SLTU:    {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_SLTU};
         ID_SLLV:    {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_SLLV};
         ID_SRLV:    {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_SRLV};
         ID_SRAV:    {w[31:26], w[10:0]} = {OP_SPECIAL, 5'd0, FN_SRAV};
         ID_MULT:    {w[31:26], w[15:0]} = {OP_SPECIAL, 10'd0, FN_MULT};
         ID_MULTU:   {w[31:26], w[15:0]} = {OP_SPECIAL, 10'd0, FN_MULTU};
         ID_DIV:     {w[31:26], w[15:0]} = {OP_SPECIAL, 10'd0, FN_DIV};
         ID_DIVU:    {w[31:26], w[15:0]} = {OP_SPECIAL, 10'd0, FN_DIVU};
         ID_MFHI:    {w[31:16], w[10:0]} = {OP_SPECIAL, 10'd0, 5'd0, FN_MFHI};
         ID_MFLO:    {w[31:16], w[10:0]} = {OP_SPECIAL, 10'd0, 5'd0, FN_MFLO};
         ID_MTHI:    {w[31:26], w[20:0]} = {OP_SPECIAL, 15'd0, FN_MTHI};
         ID_MTLO:    {w[31:26], w[20:0]} = {OP_SPECIAL, 15'd0, FN_MTLO};
         ID_JR:      {w[31:26], w[20:0]} = {OP_SPECIAL, 15'd0, FN_JR};
         ID_JALR:    {w[31:26], w[20:16], w[10:0]} = {OP_SPECIAL, 5'd0, 5'd0, FN_JALR};
         ID_SLL:     {w[31:21], w[5:0]} = {OP_SPECIAL, 5'd0, FN_SLL};
         ID_SRL:     {w[31:21], w[5:0]} = {OP_SPECIAL, 5'd0, FN_SRL};
         ID_SRA:     {w[31:21], w[5:0]} = {OP_SPECIAL, 5'd0, FN_SRA};
         ID_BREAK:   {w[31:26], w[5:0]} = {OP_SPECIAL, FN_BREAK};
         ID_SYSCALL: {w[31:26], w[5:0]} = {OP_SPECIAL, FN_SYSCALL};
         ID_MFC0:    {w[31:21], w[10:0]} = {OP_COP0, RS_MF, 11'd0};
         ID_MTC0:    {w[31:21], w[10:0]} = {OP_COP0, RS_MT, 11'd0};
         ID_ERET:    w = {OP_COP0, ERET_CODE, FN_ERET};
         ID_ADDI:    w[31:26] = OP_ADDI;
         ID_ADDIU:   w[31:26] = OP_ADDIU;
         ID_ANDI:    w[31:26] = OP_ANDI;
         ID_ORI:     w[31:26] = OP_ORI;
         ID_XORI:    w[31:26] = OP_XORI;
         ID_LUI:     w[31:21] = {OP_LUI, 5'd0};
         ID_LB:      w[31:26] = OP_LB;
         ID_LBU:     w[31:26] = OP_LBU;
         ID_LH:      w[31:26] = OP_LH;
         ID_LHU:     w[31:26] = OP_LHU;
         ID_LW:      w[31:26] = OP_LW;
         ID_SB:      w[31:26] = OP_SB;
         ID_SH:      w[31:26] = OP_SH;
         ID_SW:      w[31:26] = OP_SW;
         ID_BEQ:     w[31:26] = OP_BEQ;
         ID_BNE:     w[31:26] = OP_BNE;
         ID_BGEZ:    {w[31:26], w[20:16]} = {OP_REGIMM, RT_BGEZ};
         ID_BGTZ:    {w[31:26], w[20:16]} = {OP_BGTZ, 5'd0};
         ID_BLEZ:    {w[31:26], w[20:16]} = {OP_BLEZ, 5'd0};
         ID_BLTZ:    {w[31:26], w[20:16]} = {OP_REGIMM, RT_BLTZ};
         ID_BGEZAL:  {w[31:26], w[20:16]} = {OP_REGIMM, RT_BGEZAL};
         ID_BLTZAL:  {w[31:26], w[20:16]} = {OP_REGIMM, RT_BLTZAL};
         ID_SLTI:    w[31:26] = OP_SLTI;
         ID_SLTIU:   w[31:26] = OP_SLTIU;
         ID_J:       w[31:26] = OP_J;
         ID_JAL:     w[31:26] = OP_JAL;
         default: ;
      endcase
      return w;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycle_count, msg);
      fail_count++;
   endtask

   // Driver: a word stays on the port until taken; idle bursts come in
   // phases, with a calm stretch every third phase and at the tail.
   always @(negedge clock) begin : driver
      int unsigned phase;
      if (reset) begin
         start <= 1'b0;
      end else if (sent_count != taken_count) begin
         // Hold the current word until the block takes it.
      end else if (gap_left != 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (word_q.size() == 0) begin
         start <= 1'b0;
      end else begin
         phase = (sent_count / 150) % 3;
         if (word_q.size() > CALM_TAIL && phase != 0 &&
             $urandom_range(0, 99) < (phase == 1 ? 10 : 40)) begin
            start <= 1'b0;
            gap_left <= $urandom_range(0, 16);
         end else begin
            start <= 1'b1;
            req_instr_word <= word_q.pop_front();
            sent_count <= sent_count + 1;
         end
      end
   end

   // Monitor: check each result against the oldest expectation, then
   // record the word taken at this edge.
   always @(posedge clock) begin : monitor
      decoded_type want;
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_strobe === 1'b1) begin
            if (decoded_q.size() == 0) begin
               report_mismatch("result with no word pending");
            end else begin
               want = decoded_q.pop_front();
               if (rsp_insn_id !== want.id)
                  report_mismatch($sformatf("word %h insn_id got %0d want %0d",
                                            want.word, rsp_insn_id, want.id));
               if (rsp_src_reg !== want.rs)
                  report_mismatch($sformatf("word %h src_reg got %0d want %0d",
                                            want.word, rsp_src_reg, want.rs));
               if (rsp_tgt_reg !== want.rt)
                  report_mismatch($sformatf("word %h tgt_reg got %0d want %0d",
                                            want.word, rsp_tgt_reg, want.rt));
               if (rsp_dst_reg !== want.rd)
                  report_mismatch($sformatf("word %h dst_reg got %0d want %0d",
                                            want.word, rsp_dst_reg, want.rd));
               if (rsp_shift_amount !== want.sh)
                  report_mismatch($sformatf("word %h shift_amount got %0d want %0d",
                                            want.word, rsp_shift_amount, want.sh));
               if (rsp_immediate !== want.imm)
                  report_mismatch($sformatf("word %h immediate got %h want %h",
                                            want.word, rsp_immediate, want.imm));
               if (rsp_target !== want.tgt)
                  report_mismatch($sformatf("word %h target got %h want %h",
                                            want.word, rsp_target, want.tgt));
            end
         end else if (rsp_strobe !== 1'b0) begin
            report_mismatch("result strobe is unknown");
         end
         if (start && busy === 1'b0) begin
            decoded_q.push_back(decode_expected(req_instr_word));
            taken_count <= taken_count + 1;
         end
      end
   end

   // Stimulus: directed corner words first, then random words.
   initial begin : stimulus
      logic [WORD_W-1:0] w;
      int unsigned       mode;
      // All-zero word, all-one word, and sll that only differs from nop in rd.
      word_q.push_back('0);
      word_q.push_back('1);
      word_q.push_back({OP_SPECIAL, 5'd0, 5'd0, 5'd1, 5'd0, FN_SLL});
      // Register forms with a nonzero shift amount, and shifts with rs set.
      word_q.push_back({OP_SPECIAL, 5'd3, 5'd4, 5'd5, 5'd1, FN_ADD});
      word_q.push_back({OP_SPECIAL, 5'd0, 5'd7, 5'd9, 5'd31, FN_SRA});
      word_q.push_back({OP_SPECIAL, 5'd4, 5'd0, 5'd2, 5'd3, FN_SLL});
      word_q.push_back({OP_SPECIAL, 20'hFFFFF, FN_BREAK});
      word_q.push_back({OP_SPECIAL, 20'h00000, FN_SYSCALL});
      // Fields that must be zero but are not.
      word_q.push_back({OP_SPECIAL, 5'd1, 5'd0, 5'd3, 5'd0, FN_JR});
      word_q.push_back({OP_SPECIAL, 5'd31, 5'd31, 5'd1, 5'd0, FN_MULT});
      word_q.push_back({OP_SPECIAL, 5'd1, 5'd0, 5'd2, 5'd0, FN_MFHI});
      word_q.push_back({OP_SPECIAL, 5'd4, 5'd1, 5'd2, 5'd0, FN_JALR});
      // Coprocessor-0 moves and eret, with near misses.
      word_q.push_back({OP_COP0, ERET_CODE, FN_ERET});
      word_q.push_back({OP_COP0, ERET_CODE ^ 20'h00001, FN_ERET});
      word_q.push_back({OP_COP0, RS_MF, 5'd12, 5'd14, 11'd0});
      word_q.push_back({OP_COP0, RS_MT, 5'd31, 5'd31, 11'd0});
      word_q.push_back({OP_COP0, RS_MT, 5'd1, 5'd2, 5'd1, 6'd0});
      // Immediate forms, branches and jumps at the field extremes.
      word_q.push_back({OP_LUI, 5'd0, 5'd31, 16'hFFFF});
      word_q.push_back({OP_LUI, 5'd1, 5'd0, 16'h0000});
      word_q.push_back({OP_REGIMM, 5'd31, RT_BGEZAL, 16'h8000});
      word_q.push_back({OP_REGIMM, 5'd0, 5'd2, 16'h0001});
      word_q.push_back({OP_BGTZ, 5'd5, 5'd1, 16'h0000});
      word_q.push_back({OP_SLTIU, 5'd31, 5'd0, 16'hFFFF});
      word_q.push_back({OP_J, 26'h3FFFFFF});
      word_q.push_back({OP_JAL, 26'h0000000});

      // Mostly well-formed words, some with one bit flipped, some pure noise.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         mode = $urandom_range(0, 99);
         w = build_word(insn_id_type'($urandom_range(0, ID_UNKNOWN)));
         if (mode >= 70 && mode < 85)
            w = w ^ (32'h1 << $urandom_range(0, WORD_W - 1));
         else if (mode >= 85)
            w = $urandom;
         word_q.push_back(w);
      end

      while (word_q.size() != 0 || sent_count != taken_count || decoded_q.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (fail_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin : watchdog
      wait (cycle_count >= LIMIT_CYCLES);
      $display("status: fail");
      $finish;
   end

endmodule

/* filelist.f */
design/mid_pkg.sv
design/mid_decode.sv
design/mips_instruction_decoder_core.sv
bench/tb_top.sv
